// File: rtl/core/hcbt_pkg.sv
// shared types, codes and helpers of the chunked body tracker
package hcbt_pkg;

	localparam int SIZE_DIGITS_DEF = 8;

	localparam int ACC_W = 32;
	localparam int REM_W = 33;
	localparam int DC_W  = 4;
	localparam int PH_W  = 3;
	localparam int CLS_W = 3;
	localparam int ST_W  = 2;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [REM_W-1:0] TRAILER_LEN = REM_W'(2);

	// parser phases
	localparam logic [PH_W-1:0] PH_SIZE  = 3'd0;
	localparam logic [PH_W-1:0] PH_SKIP  = 3'd1;
	localparam logic [PH_W-1:0] PH_DATA  = 3'd2;
	localparam logic [PH_W-1:0] PH_FINAL = 3'd3;
	localparam logic [PH_W-1:0] PH_ERROR = 3'd4;

	// byte classes
	localparam logic [CLS_W-1:0] CLS_DIGIT   = 3'd0;
	localparam logic [CLS_W-1:0] CLS_LINEEND = 3'd1;
	localparam logic [CLS_W-1:0] CLS_PAYLOAD = 3'd2;
	localparam logic [CLS_W-1:0] CLS_TRAILER = 3'd3;
	localparam logic [CLS_W-1:0] CLS_AFTER   = 3'd4;
	localparam logic [CLS_W-1:0] CLS_ERROR   = 3'd5;

	// packet status codes
	localparam logic [ST_W-1:0] ST_NEXT     = 2'd0;
	localparam logic [ST_W-1:0] ST_MORE     = 2'd1;
	localparam logic [ST_W-1:0] ST_FINISHED = 2'd2;
	localparam logic [ST_W-1:0] ST_ERROR    = 2'd3;

	typedef struct packed {
		logic [PH_W-1:0]  phase;
		logic [ACC_W-1:0] size_acc;
		logic [DC_W-1:0]  digit_cnt;
		logic [REM_W-1:0] remaining;
	} hcbt_state_t;

	typedef struct packed {
		logic [CLS_W-1:0] byte_class;
		logic [7:0]       payload_out;
		logic [REM_W-1:0] bytes_left;
		logic [ST_W-1:0]  packet_status;
		logic             status_valid;
	} hcbt_result_t;

	// hex digit test and value
	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

endpackage

// File: rtl/core/hcbt_if.sv
// beat channels of the chunked body tracker
interface hcbt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       packet_end;

	modport source (output valid, body_byte, packet_end, input ready);
	modport sink (input valid, body_byte, packet_end, output ready);
endinterface

interface hcbt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  byte_class;
	logic [7:0]  payload_out;
	logic [32:0] bytes_left;
	logic [1:0]  packet_status;
	logic        status_valid;

	modport source (output valid, byte_class, payload_out, bytes_left, packet_status,
		status_valid, input ready);
	modport sink (input valid, byte_class, payload_out, bytes_left, packet_status,
		status_valid, output ready);
endinterface

// File: rtl/core/hcbt_step.sv
// next-state and classification logic for one body byte
module hcbt_step #(
	parameter int SIZE_DIGITS = hcbt_pkg::SIZE_DIGITS_DEF
) (
	input  hcbt_pkg::hcbt_state_t  cur,
	input  logic [7:0]             body_byte,
	input  logic                   packet_end,
	output hcbt_pkg::hcbt_state_t  nxt,
	output hcbt_pkg::hcbt_result_t res
);
	import hcbt_pkg::*;

	logic [REM_W-1:0] rem_dec;

	assign rem_dec = (cur.remaining != '0) ? cur.remaining - REM_W'(1) : cur.remaining;

	always_comb begin
		nxt = cur;
		res.byte_class  = CLS_ERROR;
		res.payload_out = 8'h00;
		unique case (cur.phase)
			PH_SIZE: begin
				if (body_byte == CHAR_CR) begin
					if (cur.digit_cnt == '0) begin
						nxt.phase = PH_ERROR;
					end else begin
						res.byte_class = CLS_LINEEND;
						nxt.phase      = PH_SKIP;
					end
				end else if (is_hex(body_byte) && cur.digit_cnt < DC_W'(SIZE_DIGITS)) begin
					nxt.size_acc   = {cur.size_acc[ACC_W-5:0], hex_val(body_byte)};
					nxt.digit_cnt  = cur.digit_cnt + DC_W'(1);
					res.byte_class = CLS_DIGIT;
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			PH_SKIP: begin
				res.byte_class = CLS_LINEEND;
				if (cur.size_acc == '0) begin
					nxt.phase     = PH_FINAL;
					nxt.remaining = '0;
				end else begin
					nxt.remaining = {1'b0, cur.size_acc} + TRAILER_LEN;
					nxt.phase     = PH_DATA;
				end
			end
			PH_DATA: begin
				if (cur.remaining > TRAILER_LEN) begin
					res.byte_class  = CLS_PAYLOAD;
					res.payload_out = body_byte;
				end else begin
					res.byte_class = CLS_TRAILER;
				end
				nxt.remaining = rem_dec;
				if (rem_dec == '0) begin
					nxt.phase     = PH_SIZE;
					nxt.size_acc  = '0;
					nxt.digit_cnt = '0;
				end
			end
			PH_FINAL: begin
				res.byte_class = CLS_AFTER;
			end
			default: begin
				nxt.phase = PH_ERROR;
			end
		endcase

		res.bytes_left    = nxt.remaining;
		res.status_valid  = packet_end;
		res.packet_status = ST_NEXT;
		if (packet_end) begin
			if (nxt.phase == PH_ERROR) begin
				res.packet_status = ST_ERROR;
			end else if (nxt.phase == PH_FINAL) begin
				res.packet_status = ST_FINISHED;
			end else if (nxt.phase == PH_SIZE && nxt.digit_cnt == '0) begin
				res.packet_status = ST_NEXT;
			end else begin
				res.packet_status = ST_MORE;
			end
		end
	end

endmodule

// File: rtl/core/http_chunked_body_tracker.sv
// chunked transfer body tracker: classifies each body byte, reports per packet
//
//  channel  dir  beat contents
//  -------  ---  -------------------------------------------------------------
//  body     in   body_byte, packet_end
//  result   out  byte_class, payload_out, bytes_left, packet_status, status_valid
//
// one byte per cycle sustained while result is taken; a byte's result appears in the cycle after its beat
// parser state and the result register are updated in the same edge, so the
// critical path is one 33-bit decrement and compare plus selection
// arst_n clears the parser to the size line phase and empties the result register
// body is ready whenever the result register is empty or being taken, so a stall
// on result holds the pending result and blocks body only while it is full
module http_chunked_body_tracker #(
	parameter int SIZE_DIGITS = hcbt_pkg::SIZE_DIGITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	hcbt_in_if.sink    body,
	hcbt_out_if.source result
);
	import hcbt_pkg::*;

	// parser state
	hcbt_state_t  state_q;
	hcbt_state_t  state_nxt;
	hcbt_result_t res_nxt;

	// result register
	hcbt_result_t res_q;
	logic         res_valid_q;

	logic body_acc;

	assign body.ready = !res_valid_q || result.ready;
	assign body_acc   = body.valid && body.ready;

	hcbt_step #(
		.SIZE_DIGITS (SIZE_DIGITS)
	) u_step (
		.cur        (state_q),
		.body_byte  (body.body_byte),
		.packet_end (body.packet_end),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// state moves only on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= PH_SIZE;
			state_q.size_acc  <= '0;
			state_q.digit_cnt <= '0;
			state_q.remaining <= '0;
		end else if (body_acc) begin
			state_q <= state_nxt;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (body_acc) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (body_acc) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.byte_class    = res_q.byte_class;
	assign result.payload_out   = res_q.payload_out;
	assign result.bytes_left    = res_q.bytes_left;
	assign result.packet_status = res_q.packet_status;
	assign result.status_valid  = res_q.status_valid;

	// error phase is sticky until reset
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_ERROR |=> state_q.phase == PH_ERROR)
		else $error("error phase left without reset");

	// in the data phase something is always still owed
	a_data_owes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DATA |-> state_q.remaining != '0)
		else $error("data phase with nothing owed");

	// a pending after-final result means the parser stays in the final phase
	a_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.byte_class == CLS_AFTER |-> state_q.phase == PH_FINAL)
		else $error("after-final byte reported outside final phase");

	// digit count never passes the limit
	a_digit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.digit_cnt <= DC_W'(SIZE_DIGITS))
		else $error("size line digit count over limit");

endmodule

// File: bench/tb_http_chunked_body_tracker.sv
// self-checking bench for the chunked body tracker: random chunk streams against a byte-level tracker model
`timescale 1ns / 1ps

module tb_http_chunked_body_tracker;
	import hcbt_pkg::*;

	// ascii bytes used to build size lines and line ends
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_NL    = 8'h0a;

	localparam int SIZE_DIGITS = SIZE_DIGITS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 64;

	// the run picks one ending: the final chunk and an error stick until reset, a huge chunk outlasts the run
	typedef enum int {
		END_FINAL_CHUNK,
		END_BAD_CHAR,
		END_EMPTY_LINE,
		END_LONG_SIZE,
		END_HUGE_CHUNK
	} ending_t;

	logic clk;
	logic arst_n;

	hcbt_in_if  body_if ();
	hcbt_out_if res_if ();

	http_chunked_body_tracker #(
		.SIZE_DIGITS(SIZE_DIGITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.body(body_if),
		.result(res_if)
	);

	// tracker model state, mirrors the parser after every accepted beat
	logic [PH_W-1:0]  trk_phase;
	logic [ACC_W-1:0] trk_size;
	logic [DC_W-1:0]  trk_digits;
	logic [REM_W-1:0] trk_left;

	// results owed by the block, oldest first
	hcbt_result_t owed_results[$];

	int errors;
	int beats_in;
	int results_checked;
	int packet_ends;
	int cycle_cnt;

	// sender burst shaping
	int burst_left;
	bit gaps_on;

	// receiver stall pattern, plus long hold-offs requested by the tests
	int hold_reqs;
	int hold_served;
	int hold_cnt;
	int stall_mode;
	int mode_left;
	int stall_period;

	ending_t ending;

	hcbt_result_t want;
	hcbt_result_t got;

	always #6 clk = ~clk;

	// byte-level model of the tracker: updates the state and returns the result for one beat
	function automatic hcbt_result_t track_byte(input logic [7:0] b, input logic pend);
		hcbt_result_t r;
		logic [7:0] val;
		logic is_digit;
		r = '0;
		r.byte_class = CLS_ERROR;
		is_digit = 1'b1;
		val = 8'h00;
		if (b >= CH_0 && b <= CH_9) begin
			val = b - CH_0;
		end else if (b >= CH_UA && b <= CH_UF) begin
			val = b - CH_UA + 8'd10;
		end else if (b >= CH_LA && b <= CH_LOW_F) begin
			val = b - CH_LA + 8'd10;
		end else begin
			is_digit = 1'b0;
		end

		case (trk_phase)
			PH_SIZE: begin
				if (b == CHAR_CR) begin
					// a CR with no digits before it is an empty size line
					if (trk_digits == 0) begin
						trk_phase = PH_ERROR;
					end else begin
						r.byte_class = CLS_LINEEND;
						trk_phase = PH_SKIP;
					end
				end else if (is_digit && trk_digits < SIZE_DIGITS) begin
					trk_size = {trk_size[ACC_W-5:0], val[3:0]};
					trk_digits = trk_digits + 1'b1;
					r.byte_class = CLS_DIGIT;
				end else begin
					// bad character or one digit too many
					trk_phase = PH_ERROR;
				end
			end
			PH_SKIP: begin
				// byte after CR goes by unchecked
				r.byte_class = CLS_LINEEND;
				if (trk_size == 0) begin
					trk_phase = PH_FINAL;
					trk_left = '0;
				end else begin
					trk_left = {1'b0, trk_size} + REM_W'(2);
					trk_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				if (trk_left > 2) begin
					r.byte_class = CLS_PAYLOAD;
					r.payload_out = b;
				end else begin
					r.byte_class = CLS_TRAILER;
				end
				if (trk_left > 0) begin
					trk_left = trk_left - 1'b1;
				end
				if (trk_left == 0) begin
					trk_phase = PH_SIZE;
					trk_size = '0;
					trk_digits = '0;
				end
			end
			PH_FINAL: begin
				r.byte_class = CLS_AFTER;
			end
			default: begin
				trk_phase = PH_ERROR;
			end
		endcase

		r.bytes_left = trk_left;
		r.status_valid = pend;
		if (pend) begin
			if (trk_phase == PH_ERROR) begin
				r.packet_status = ST_ERROR;
			end else if (trk_phase == PH_FINAL) begin
				r.packet_status = ST_FINISHED;
			end else if (trk_phase == PH_SIZE && trk_digits == 0) begin
				r.packet_status = ST_NEXT;
			end else begin
				r.packet_status = ST_MORE;
			end
		end
		return r;
	endfunction

	// beat monitor and scoreboard, both on the rising edge
	// the body beat is modelled first so a same-edge result could still find its expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (body_if.valid && body_if.ready) begin
				owed_results.push_back(track_byte(body_if.body_byte, body_if.packet_end));
				beats_in++;
			end
			if (res_if.valid && res_if.ready) begin
				got.byte_class = res_if.byte_class;
				got.payload_out = res_if.payload_out;
				got.bytes_left = res_if.bytes_left;
				got.packet_status = res_if.packet_status;
				got.status_valid = res_if.status_valid;
				if (owed_results.size() == 0) begin
					$error("result beat with nothing owed: class %0d", got.byte_class);
					errors++;
				end else begin
					want = owed_results.pop_front();
					results_checked++;
					if (want.status_valid) begin
						packet_ends++;
					end
					if (got.byte_class !== want.byte_class) begin
						$error("byte_class: expected %0d, got %0d",
							want.byte_class, got.byte_class);
						errors++;
					end
					if (got.payload_out !== want.payload_out) begin
						$error("payload_out: expected %02h, got %02h",
							want.payload_out, got.payload_out);
						errors++;
					end
					if (got.bytes_left !== want.bytes_left) begin
						$error("bytes_left: expected %0h, got %0h",
							want.bytes_left, got.bytes_left);
						errors++;
					end
					if (got.packet_status !== want.packet_status) begin
						$error("packet_status: expected %0d, got %0d",
							want.packet_status, got.packet_status);
						errors++;
					end
					if (got.status_valid !== want.status_valid) begin
						$error("status_valid: expected %0d, got %0d",
							want.status_valid, got.status_valid);
						errors++;
					end
				end
			end
		end
	end

	// receiver: a changing stall pattern, overridden by long hold-offs counted here
	always @(negedge clk) begin
		if (hold_reqs != hold_served) begin
			hold_served++;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_if.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 150);
				stall_period = $urandom_range(2, 6);
			end
			mode_left--;
			case (stall_mode)
				0: res_if.ready <= 1'b1;
				1: res_if.ready <= ($urandom_range(0, 1) == 0);
				2: res_if.ready <= ($urandom_range(0, 6) != 0);
				default: res_if.ready <= ((mode_left % stall_period) != 0);
			endcase
		end
	end

	// watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
			owed_results.size());
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic coin_packet_end();
		return $urandom_range(0, 7) == 0;
	endfunction

	// chunk sizes: mostly short, now and then a long one
	function automatic int pick_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) begin
			return $urandom_range(1, 24);
		end else if (roll < 95) begin
			return $urandom_range(25, 120);
		end
		return $urandom_range(121, 400);
	endfunction

	// offers one body beat, with a random idle gap at the start of each burst when gaps are on
	task automatic send_byte(input logic [7:0] b, input logic pend);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				@(negedge clk);
				body_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		body_if.valid <= 1'b1;
		body_if.body_byte <= b;
		body_if.packet_end <= pend;
		@(posedge clk);
		while (!body_if.ready) @(posedge clk);
	endtask

	// stops offering and waits until every owed result has been taken
	task automatic drain();
		@(negedge clk);
		body_if.valid <= 1'b0;
		burst_left = 0;
		while (owed_results.size() != 0) @(posedge clk);
	endtask

	// hex size line in mixed case, CR and the unchecked byte after it
	task automatic send_size_line(input logic [31:0] size, input int ndig);
		logic [3:0] nib;
		logic [7:0] c;
		for (int i = ndig - 1; i >= 0; i--) begin
			nib = 4'(size >> (4 * i));
			if (nib < 10) begin
				c = CH_0 + nib;
			end else begin
				c = ($urandom_range(0, 1) ? CH_UA : CH_LA) + nib - 8'd10;
			end
			send_byte(c, coin_packet_end());
		end
		send_byte(CHAR_CR, coin_packet_end());
		// mostly LF, sometimes anything since it is not checked
		send_byte(($urandom_range(0, 3) != 0) ? CH_NL : 8'($urandom_range(0, 255)),
			coin_packet_end());
	endtask

	// one well-formed chunk with random payload and packet splits
	task automatic send_chunk(input int size);
		int nmin;
		bit tidy;
		nmin = 1;
		while (nmin < SIZE_DIGITS && (size >> (4 * nmin)) != 0) nmin++;
		send_size_line(size, $urandom_range(nmin, SIZE_DIGITS));
		for (int i = 0; i < size; i++) begin
			send_byte(8'($urandom_range(0, 255)), coin_packet_end());
		end
		tidy = $urandom_range(0, 3) != 0;
		send_byte(tidy ? CHAR_CR : 8'($urandom_range(0, 255)), coin_packet_end());
		// packets often close right on the chunk boundary
		send_byte(tidy ? CH_NL : 8'($urandom_range(0, 255)), $urandom_range(0, 1));
	endtask

	// short hand-built chunks: payload extremes, a full-width size line, splits in odd places
	task automatic test_directed();
		gaps_on = 1'b0;
		// one-byte chunk of 0x00, packet closes exactly on the boundary
		send_byte(CH_0 + 8'd1, 1'b0);
		send_byte(CHAR_CR, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(CHAR_CR, 1'b0);
		send_byte(CH_NL, 1'b1);
		// eight digits with leading zeros, packet split inside the size line
		for (int i = 0; i < 7; i++) begin
			send_byte(CH_0, i == 3);
		end
		send_byte(CH_0 + 8'd2, 1'b0);
		send_byte(CHAR_CR, 1'b0);
		// skipped byte and trailer bytes that are not CR/LF at all
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h5a, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
		drain();
	endtask

	// bulk of the run: random chunks with random gaps and stalls
	task automatic test_random_chunks();
		int start;
		gaps_on = 1'b1;
		start = beats_in;
		while (beats_in - start < 150) begin
			send_chunk(pick_size());
		end
	endtask

	// receiver holds off for a long stretch while the sender keeps offering back to back
	task automatic test_result_stall();
		gaps_on = 1'b0;
		hold_reqs++;
		repeat (3) send_chunk($urandom_range(8, 16));
		gaps_on = 1'b1;
		drain();
	endtask

	// sender waits for every owed result, then streams with and without gaps
	task automatic test_sender_pause();
		drain();
		gaps_on = 1'b0;
		repeat (2) send_chunk($urandom_range(1, 20));
		gaps_on = 1'b1;
		repeat (2) send_chunk(pick_size());
		drain();
	endtask

	// closes the stream one of the ways above, then shows the state holds or the huge chunk goes on
	task automatic test_ending();
		logic [7:0] c;
		ending = ending_t'($urandom_range(0, 4));
		gaps_on = 1'b1;
		case (ending)
			END_FINAL_CHUNK: begin
				send_size_line(32'h0, $urandom_range(1, 3));
			end
			END_BAD_CHAR: begin
				// a few good digits may come first
				repeat ($urandom_range(0, 3)) send_byte(CH_0 + 8'($urandom_range(1, 9)), 1'b0);
				do begin
					c = 8'($urandom_range(0, 255));
				end while ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
					(c >= CH_LA && c <= CH_LOW_F) || c == CHAR_CR);
				send_byte(c, coin_packet_end());
			end
			END_EMPTY_LINE: begin
				send_byte(CHAR_CR, coin_packet_end());
			end
			END_LONG_SIZE: begin
				// one digit more than the size line may hold
				for (int i = 0; i <= SIZE_DIGITS; i++) begin
					send_byte(($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'($urandom_range(0, 5)),
						coin_packet_end());
				end
			end
			default: begin
				// largest size: bytes_left starts at its widest value
				send_size_line(32'hffff_ffff, SIZE_DIGITS);
			end
		endcase
		for (int i = 0; i < 24; i++) begin
			send_byte(8'($urandom_range(0, 255)), (i == 23) || coin_packet_end());
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		body_if.valid = 1'b0;
		body_if.body_byte = 8'h00;
		body_if.packet_end = 1'b0;
		res_if.ready = 1'b0;
		trk_phase = PH_SIZE;
		trk_size = '0;
		trk_digits = '0;
		trk_left = '0;
		errors = 0;
		beats_in = 0;
		results_checked = 0;
		packet_ends = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_reqs = 0;
		hold_served = 0;
		hold_cnt = 0;
		stall_mode = 0;
		mode_left = 0;
		stall_period = 2;
		ending = END_FINAL_CHUNK;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_chunks();
		test_result_stall();
		test_sender_pause();
		test_ending();

		// each result is registered in the cycle after its beat, the spare cycles catch strays
		drain();
		repeat (4) @(posedge clk);
		if (owed_results.size() != 0) begin
			$error("%0d results never arrived", owed_results.size());
			errors++;
		end

		$display("covered %0d body beats in chunked streams, %0d results checked, %0d packet ends",
			beats_in, results_checked, packet_ends);
		$display("stream closed by %s, with long receiver hold-off and sender pause",
			ending.name());
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/hcbt_pkg.sv
rtl/core/hcbt_if.sv
rtl/core/hcbt_step.sv
rtl/core/http_chunked_body_tracker.sv
bench/tb_http_chunked_body_tracker.sv
